// ===== design/tpv_pkg.sv =====
// Shared types, widths and constants of the three-axis PID velocity block.
// No dependencies; every other design file imports it.
`default_nettype none

package tpv_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int GAIN_W = 24;
    localparam int LIM_W  = 15;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;

    localparam int STOP_RANGE = 307;
    localparam int TICK_DT    = 20;

    // x / TICK_DT as (x >> 2) * ceil(2^24 / 5) >> 24, exact for 24-bit x
    localparam int DT_SHIFT    = 2;
    localparam int DT_ODD      = TICK_DT >> DT_SHIFT;
    localparam int RECIP_SHIFT = 24;
    localparam int DT_RECIP    = ((2 ** RECIP_SHIFT) + DT_ODD - 1) / DT_ODD;
    localparam int RECIP_W     = 22;
    localparam int DQ_W        = 20;
    localparam int KDR_W       = 5;

    localparam int ERR_W  = 17;
    localparam int DIFF_W = 18;
    localparam int ACC_W  = 32;
    localparam int ACCX_W = ACC_W + 1;
    localparam int P_W    = 42;
    localparam int I_W    = 56;
    localparam int Q_W    = 39;
    localparam int RD_W   = 23;
    localparam int SUM_W  = 58;
    localparam int FRAC_W = 16;
    localparam int SH_W   = SUM_W - FRAC_W;

    typedef struct packed {
        logic signed [IN_W-1:0] near_x;
        logic signed [IN_W-1:0] near_y;
        logic signed [IN_W-1:0] far_x;
    } tpv_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] turn_rate;
        logic signed [OUT_W-1:0] side_speed;
        logic signed [OUT_W-1:0] forward_speed;
    } tpv_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [DQ_W-1:0]   kd_q;
        logic [KDR_W-1:0]  kd_r;
        logic [LIM_W-1:0]  limit;
    } tpv_gain_t;

    typedef struct packed {
        tpv_gain_t lin;
        tpv_gain_t ang;
    } tpv_cfg_t;

    typedef struct packed {
        logic adv;
        logic upd;
    } tpv_ctl_t;

    typedef enum logic [2:0] {
        REG_KP_LIN    = 3'd0,
        REG_KI_LIN    = 3'd1,
        REG_KD_LIN    = 3'd2,
        REG_KP_ANG    = 3'd3,
        REG_KI_ANG    = 3'd4,
        REG_KD_ANG    = 3'd5,
        REG_LIN_LIMIT = 3'd6,
        REG_ANG_LIMIT = 3'd7
    } tpv_reg_t;

    function automatic logic [DQ_W-1:0] div_dt(input logic [GAIN_W-1:0] x);
        logic [GAIN_W-DT_SHIFT+RECIP_W-1:0] prod;
        prod = (GAIN_W-DT_SHIFT+RECIP_W)'(x[GAIN_W-1:DT_SHIFT])
             * (GAIN_W-DT_SHIFT+RECIP_W)'(DT_RECIP);
        return prod[RECIP_SHIFT +: DQ_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/tpv_regs.sv =====
// APB register file: gains and limits, plus the derivative gains split into
// quotient and remainder by the time step. Depends on tpv_pkg.
`default_nettype none

module tpv_regs import tpv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output tpv_cfg_t          cfg
);

    localparam int KP_LIN_RST = 65536;
    localparam int KI_LIN_RST = 66;
    localparam int KD_LIN_RST = 65536;
    localparam int KP_ANG_RST = 65536;
    localparam int KI_ANG_RST = 655;
    localparam int KD_ANG_RST = 655360;
    localparam int LIN_LIMIT_RST = 307;
    localparam int ANG_LIMIT_RST = 512;

    logic [GAIN_W-1:0] kp_lin_reg, ki_lin_reg, kd_lin_reg;
    logic [GAIN_W-1:0] kp_ang_reg, ki_ang_reg, kd_ang_reg;
    logic [LIM_W-1:0]  lin_limit_reg, ang_limit_reg;
    logic [DQ_W-1:0]   kd_lin_q_reg, kd_ang_q_reg;
    logic [KDR_W-1:0]  kd_lin_r_reg, kd_ang_r_reg;

    logic              wr;
    tpv_reg_t          idx;
    logic [GAIN_W-1:0] wgain;
    logic [DQ_W-1:0]   kd_q_next;
    logic [GAIN_W-1:0] kd_q_x20;
    logic [KDR_W-1:0]  kd_r_next;

    assign wr    = psel & penable & pwrite;
    assign idx   = tpv_reg_t'(paddr[ADDR_W-1:2]);
    assign wgain = pwdata[GAIN_W-1:0];

    assign kd_q_next = div_dt(wgain);
    assign kd_q_x20  = {kd_q_next, 4'b0000} + {2'b00, kd_q_next, 2'b00};
    assign kd_r_next = KDR_W'(wgain - kd_q_x20);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_lin_reg    <= GAIN_W'(KP_LIN_RST);
            ki_lin_reg    <= GAIN_W'(KI_LIN_RST);
            kd_lin_reg    <= GAIN_W'(KD_LIN_RST);
            kp_ang_reg    <= GAIN_W'(KP_ANG_RST);
            ki_ang_reg    <= GAIN_W'(KI_ANG_RST);
            kd_ang_reg    <= GAIN_W'(KD_ANG_RST);
            lin_limit_reg <= LIM_W'(LIN_LIMIT_RST);
            ang_limit_reg <= LIM_W'(ANG_LIMIT_RST);
            kd_lin_q_reg  <= DQ_W'(KD_LIN_RST / TICK_DT);
            kd_lin_r_reg  <= KDR_W'(KD_LIN_RST % TICK_DT);
            kd_ang_q_reg  <= DQ_W'(KD_ANG_RST / TICK_DT);
            kd_ang_r_reg  <= KDR_W'(KD_ANG_RST % TICK_DT);
        end else if (wr) begin
            case (idx)
                REG_KP_LIN: kp_lin_reg <= wgain;
                REG_KI_LIN: ki_lin_reg <= wgain;
                REG_KD_LIN: begin
                    kd_lin_reg   <= wgain;
                    kd_lin_q_reg <= kd_q_next;
                    kd_lin_r_reg <= kd_r_next;
                end
                REG_KP_ANG: kp_ang_reg <= wgain;
                REG_KI_ANG: ki_ang_reg <= wgain;
                REG_KD_ANG: begin
                    kd_ang_reg   <= wgain;
                    kd_ang_q_reg <= kd_q_next;
                    kd_ang_r_reg <= kd_r_next;
                end
                REG_LIN_LIMIT: lin_limit_reg <= pwdata[LIM_W-1:0];
                REG_ANG_LIMIT: ang_limit_reg <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_KP_LIN:    prdata = DATA_W'(kp_lin_reg);
            REG_KI_LIN:    prdata = DATA_W'(ki_lin_reg);
            REG_KD_LIN:    prdata = DATA_W'(kd_lin_reg);
            REG_KP_ANG:    prdata = DATA_W'(kp_ang_reg);
            REG_KI_ANG:    prdata = DATA_W'(ki_ang_reg);
            REG_KD_ANG:    prdata = DATA_W'(kd_ang_reg);
            REG_LIN_LIMIT: prdata = DATA_W'(lin_limit_reg);
            REG_ANG_LIMIT: prdata = DATA_W'(ang_limit_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.lin.kp    = kp_lin_reg;
    assign cfg.lin.ki    = ki_lin_reg;
    assign cfg.lin.kd_q  = kd_lin_q_reg;
    assign cfg.lin.kd_r  = kd_lin_r_reg;
    assign cfg.lin.limit = lin_limit_reg;
    assign cfg.ang.kp    = kp_ang_reg;
    assign cfg.ang.ki    = ki_ang_reg;
    assign cfg.ang.kd_q  = kd_ang_q_reg;
    assign cfg.ang.kd_r  = kd_ang_r_reg;
    assign cfg.ang.limit = ang_limit_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        kd_lin_r_reg < KDR_W'(TICK_DT) && kd_ang_r_reg < KDR_W'(TICK_DT))
        else $error("kd remainder out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (GAIN_W'(kd_lin_q_reg) * GAIN_W'(TICK_DT) + GAIN_W'(kd_lin_r_reg)) == kd_lin_reg
        && (GAIN_W'(kd_ang_q_reg) * GAIN_W'(TICK_DT) + GAIN_W'(kd_ang_r_reg))
           == kd_ang_reg)
        else $error("kd split does not rebuild kd");
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr && idx == REG_LIN_LIMIT |=> lin_limit_reg == $past(pwdata[LIM_W-1:0]))
        else $error("lin_limit write lost");
`endif

endmodule

`default_nettype wire

// ===== design/tpv_err.sv =====
// Error stage: yaw, side (difference / 3) and forward errors of one beat,
// registered. Depends on tpv_pkg.
`default_nettype none

module tpv_err import tpv_pkg::*; (
    input  logic                    aclk,
    input  tpv_ctl_t                ctl,
    input  tpv_in_t                 in_data,
    output logic signed [ERR_W-1:0] yaw_err,
    output logic signed [ERR_W-1:0] side_err,
    output logic signed [ERR_W-1:0] fwd_err
);

    // |d| / 3 as |d| * ceil(2^18 / 3) >> 18, exact below 2^17
    localparam int DIV3_SHIFT = 18;
    localparam int DIV3_RECIP = ((2 ** DIV3_SHIFT) + 2) / 3;
    localparam int PROD3_W    = 2 * ERR_W;

    logic signed [ERR_W-1:0] dx;
    logic [ERR_W-1:0]        dx_mag;
    logic [PROD3_W-1:0]      prod3;
    logic signed [ERR_W-1:0] third;
    logic signed [ERR_W-1:0] side_next, yaw_next, fwd_next;
    logic signed [ERR_W-1:0] yaw_err_reg, side_err_reg, fwd_err_reg;

    assign dx     = ERR_W'(in_data.far_x) - ERR_W'(in_data.near_x);
    assign dx_mag = dx[ERR_W-1] ? ERR_W'(-dx) : ERR_W'(dx);
    assign prod3  = PROD3_W'(dx_mag) * PROD3_W'(DIV3_RECIP);
    assign third  = $signed({1'b0, prod3[DIV3_SHIFT +: ERR_W-1]});

    assign side_next = dx[ERR_W-1] ? -third : third;
    assign yaw_next  = ERR_W'(in_data.near_y);
    assign fwd_next  = ERR_W'(in_data.near_x) - ERR_W'(STOP_RANGE);

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            yaw_err_reg  <= yaw_next;
            side_err_reg <= side_next;
            fwd_err_reg  <= fwd_next;
        end
    end

    assign yaw_err  = yaw_err_reg;
    assign side_err = side_err_reg;
    assign fwd_err  = fwd_err_reg;

endmodule

`default_nettype wire

// ===== design/tpv_loop.sv =====
// One PID loop: integral and last-error state, gain products, derivative
// scaling by the time step, Q.16 floor shift and clamp. Depends on tpv_pkg.
`default_nettype none

module tpv_loop import tpv_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tpv_ctl_t                ctl,
    input  tpv_gain_t               gain,
    input  logic signed [ERR_W-1:0] err,
    output logic signed [OUT_W-1:0] out_val
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // loop state
    logic signed [ACC_W-1:0]  integ_reg;
    logic signed [ERR_W-1:0]  last_reg;

    // stage a
    logic signed [ACCX_W-1:0] acc_wide;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [ERR_W-1:0]  err_a_reg;
    logic signed [ACC_W-1:0]  acc_a_reg;
    logic signed [DIFF_W-1:0] diff_a_reg;

    // stage b
    logic [DIFF_W-1:0]        diff_mag;
    logic signed [P_W-1:0]    p_b_reg;
    logic signed [I_W-1:0]    i_b_reg;
    logic signed [Q_W-1:0]    q_b_reg;
    logic [RD_W-1:0]          rd_b_reg;
    logic                     neg_b_reg;

    // stage c
    logic [DQ_W-1:0]          dq;
    logic signed [DQ_W:0]     dq_s;
    logic signed [DQ_W:0]     dsig;
    logic signed [SUM_W-1:0]  pq_c_reg;
    logic signed [SUM_W-1:0]  id_c_reg;

    // output
    logic signed [SUM_W-1:0]  sum;
    logic signed [SH_W-1:0]   sh;
    logic signed [SH_W-1:0]   lim_s;
    logic signed [SH_W-1:0]   clamped;

    assign acc_wide = ACCX_W'(integ_reg) + ACCX_W'(err) * ACCX_W'(TICK_DT);

    always_comb begin
        if (acc_wide[ACCX_W-1] != acc_wide[ACC_W-1]) begin
            acc_next = acc_wide[ACCX_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_next = acc_wide[ACC_W-1:0];
        end
    end

    assign diff_next = DIFF_W'(err) - DIFF_W'(last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            last_reg  <= '0;
        end else if (ctl.upd) begin
            integ_reg <= acc_next;
            last_reg  <= err;
        end
    end

    assign diff_mag = diff_a_reg[DIFF_W-1] ? DIFF_W'(-diff_a_reg) : DIFF_W'(diff_a_reg);

    assign dq   = div_dt(GAIN_W'(rd_b_reg));
    assign dq_s = $signed({1'b0, dq});
    assign dsig = neg_b_reg ? -dq_s : dq_s;

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            err_a_reg  <= err;
            acc_a_reg  <= acc_next;
            diff_a_reg <= diff_next;

            p_b_reg   <= P_W'(err_a_reg) * P_W'($signed({1'b0, gain.kp}));
            i_b_reg   <= I_W'(acc_a_reg) * I_W'($signed({1'b0, gain.ki}));
            q_b_reg   <= Q_W'(diff_a_reg) * Q_W'($signed({1'b0, gain.kd_q}));
            rd_b_reg  <= RD_W'(diff_mag) * RD_W'(gain.kd_r);
            neg_b_reg <= diff_a_reg[DIFF_W-1];

            pq_c_reg <= SUM_W'(p_b_reg) + SUM_W'(q_b_reg);
            id_c_reg <= SUM_W'(i_b_reg) + SUM_W'(dsig);
        end
    end

    // floor shift by 16 is the upper bits of the sum
    assign sum   = pq_c_reg + id_c_reg;
    assign sh    = sum[SUM_W-1:FRAC_W];
    assign lim_s = SH_W'($signed({1'b0, gain.limit}));

    always_comb begin
        if (sh > lim_s) begin
            clamped = lim_s;
        end else if (sh < -lim_s) begin
            clamped = -lim_s;
        end else begin
            clamped = sh;
        end
    end

    assign out_val = OUT_W'(clamped);

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.upd |=> $stable(integ_reg) && $stable(last_reg))
        else $error("loop state moved without an update");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.upd && !err[ERR_W-1] |=> integ_reg >= $past(integ_reg))
        else $error("integral fell on a non-negative error");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.upd && err[ERR_W-1] |=> integ_reg <= $past(integ_reg))
        else $error("integral rose on a negative error");
`endif

endmodule

`default_nettype wire

// ===== design/three_axis_pid_velocity.sv =====
// Top level of the three-axis PID velocity block: input register, error
// stage, three PID loops, result register. Depends on tpv_pkg, tpv_regs,
// tpv_err and tpv_loop.
//
//   port group   dir  beat / transfer
//   s_*          in   tpv_in_t: near_x, near_y, far_x
//   m_*          out  tpv_out_t: turn_rate, side_speed, forward_speed
//   APB          in   gains and limits, 4-byte stride
//
// One beat per cycle while the output is not stalled (m_valid && !m_ready).
// The stages advance together: s_ready = !m_valid || m_ready.
// The integral and last-error update is one add and saturate per beat.
// Reset clears all valid flags and the loop state and loads the gain and limit registers with their defaults.
`default_nettype none

module three_axis_pid_velocity import tpv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tpv_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tpv_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    tpv_cfg_t  cfg;
    tpv_ctl_t  ctl;
    logic      adv;

    logic      v_in_reg, v_err_reg, v_a_reg, v_b_reg, v_c_reg, m_valid_reg;
    tpv_in_t   in_reg;
    tpv_out_t  m_data_reg;

    logic signed [ERR_W-1:0] yaw_err, side_err, fwd_err;
    logic signed [OUT_W-1:0] turn_val, side_val, fwd_val;

    assign adv     = !m_valid_reg || m_ready;
    assign ctl.adv = adv;
    assign ctl.upd = adv & v_err_reg;

    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg    <= 1'b0;
            v_err_reg   <= 1'b0;
            v_a_reg     <= 1'b0;
            v_b_reg     <= 1'b0;
            v_c_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v_in_reg    <= s_valid;
            v_err_reg   <= v_in_reg;
            v_a_reg     <= v_err_reg;
            v_b_reg     <= v_a_reg;
            v_c_reg     <= v_b_reg;
            m_valid_reg <= v_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg                   <= s_data;
            m_data_reg.turn_rate     <= turn_val;
            m_data_reg.side_speed    <= side_val;
            m_data_reg.forward_speed <= fwd_val;
        end
    end

    tpv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tpv_err u_err (
        .aclk     (aclk),
        .ctl      (ctl),
        .in_data  (in_reg),
        .yaw_err  (yaw_err),
        .side_err (side_err),
        .fwd_err  (fwd_err)
    );

    tpv_loop u_yaw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .gain    (cfg.ang),
        .err     (yaw_err),
        .out_val (turn_val)
    );

    tpv_loop u_side (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .gain    (cfg.lin),
        .err     (side_err),
        .out_val (side_val)
    );

    tpv_loop u_fwd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .gain    (cfg.lin),
        .err     (fwd_err),
        .out_val (fwd_val)
    );

endmodule

`default_nettype wire
